/* design/particle_pool_update_macros.svh */
// Assertion shorthands for the block's top-level RTL file.
// Each macro samples on the rising edge of i_clk and is disabled while in reset.
`ifndef PARTICLE_POOL_UPDATE_MACROS_SVH
`define PARTICLE_POOL_UPDATE_MACROS_SVH

// Same-cycle implication.
`define PPU_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PPU_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ppu_pkg.sv */
`timescale 1ns / 1ps

package ppu_pkg;

    // Pool size and the widths that follow from it.
    localparam int PARTICLES = 32;
    localparam int SLOT_W    = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam int CNT_W     = $clog2(PARTICLES + 1);

    // Register reset values.
    localparam logic [15:0] GRAVITY_RST = 16'd7887;
    localparam logic [19:0] TAIL_RST    = 20'd32768;

    // Life-fraction divider sizes.
    localparam int QUOT_W = 8;
    localparam int NUM_W  = 31;
    localparam int DEN_W  = 21;

    // Operation codes and register indexes.
    localparam logic OP_SPAWN    = 1'b0;
    localparam logic OP_TICK     = 1'b1;
    localparam logic CFG_GRAVITY = 1'b0;
    localparam logic CFG_TAIL    = 1'b1;

    typedef enum logic [1:0] {
        KIND_SPAWNED = 2'd0,
        KIND_DROPPED = 2'd1,
        KIND_REPORT  = 2'd2
    } t_kind;

    typedef struct packed {
        logic               op;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic [19:0]        life_span;
        logic [15:0]        time_step;
    } t_in;

    typedef struct packed {
        t_kind              kind;
        logic [4:0]         slot;
        logic signed [23:0] head_x;
        logic signed [23:0] head_y;
        logic signed [23:0] tail_x;
        logic signed [23:0] tail_y;
        logic [7:0]         fade_red;
        logic [7:0]         fade_green;
        logic [7:0]         fade_blue;
        logic [7:0]         head_alpha;
        logic               expired;
        logic               last;
    } t_out;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_sts;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPAWN,
        S_FETCH,
        S_MVX,
        S_MVY,
        S_MG,
        S_AGE,
        S_TX,
        S_TY,
        S_TEND,
        S_DMUL,
        S_DSET,
        S_DWAIT,
        S_EMIT
    } t_state;

endpackage

/* design/ppu_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// in QUOT_W bits, so only that many steps are taken.
module ppu_div import ppu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_sts         o_sts
);

    logic [NUM_W-1:0]          r_rem;
    logic [NUM_W-1:0]          r_dvs;
    logic [QUOT_W-1:0]         r_q;
    logic [$clog2(QUOT_W)-1:0] r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic                      ge;

    assign ge = (r_rem >= r_dvs);

    // Control: step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= ($clog2(QUOT_W))'(QUOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: compare, subtract and shift the divisor down.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dvs <= NUM_W'({i_den, {(QUOT_W - 1){1'b0}}});
            r_q   <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dvs;
            end
            r_dvs <= r_dvs >> 1;
            r_q   <= {r_q[QUOT_W-2:0], ge};
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.quot = r_q;

endmodule

/* design/particle_pool_update.sv */
`timescale 1ns / 1ps
`include "particle_pool_update_macros.svh"

// Particle pool with Euler integration. A spawn word takes a free slot, or
// is dropped when the pool is full, and gives one result word either way. A
// tick word walks the live particles, newest first, and gives one report word
// each; a particle whose age has reached its span skips the fade step, and
// for every other particle one shared 25x21 multiplier runs all nine products
// in turn and a bit-serial divider works through the three faded color
// channels and the head alpha one after another. A tick with no live
// particles gives no word. The block stalls its input while a word is in
// work, and a finished result waits in an output register. Configuration
// writes are taken in any cycle but are meant for idle periods.
module particle_pool_update import ppu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    // Round half up of p / 2^16.
    function automatic logic signed [29:0] rnd16(input logic signed [45:0] p);
        logic signed [45:0] s;
        s = p + 46'sd32768;
        return s[45:16];
    endfunction

    // Saturate to 24 bit signed.
    function automatic logic signed [23:0] sat24(input logic signed [30:0] v);
        logic signed [23:0] r;
        if (v > 31'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -31'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    t_state r_state, n_state;

    logic [15:0] r_gravity;
    logic [19:0] r_tail;
    t_in         r_in;

    // Particle stores, one entry per slot.
    logic signed [23:0] r_pos_x_st [PARTICLES];
    logic signed [23:0] r_pos_y_st [PARTICLES];
    logic signed [23:0] r_vel_x_st [PARTICLES];
    logic signed [23:0] r_vel_y_st [PARTICLES];
    logic [19:0]        r_age_st   [PARTICLES];
    logic [19:0]        r_span_st  [PARTICLES];
    logic [31:0]        r_col_st   [PARTICLES];

    logic [SLOT_W-1:0] r_free_stk [PARTICLES];
    logic [CNT_W-1:0]  r_free_cnt;
    logic [SLOT_W-1:0] r_live [PARTICLES];
    logic [CNT_W-1:0]  r_live_cnt;

    // Working copy of the particle being updated.
    logic [CNT_W-1:0]   r_idx;
    logic [SLOT_W-1:0]  r_slot;
    logic signed [23:0] r_px, r_py, r_vx, r_vy, r_tx, r_ty;
    logic [19:0]        r_age, r_span;
    logic [31:0]        r_col;
    logic signed [45:0] r_prod;
    logic [7:0]         r_fade [3];
    logic [7:0]         r_ha;
    logic [1:0]         r_ch;

    logic r_out_valid;
    t_out r_out, n_out;

    logic               in_acc, out_free, load_out, emit_go, spawn_go;
    logic               dead, skip, spawn_full;
    logic [CNT_W-1:0]   cur;
    logic [SLOT_W-1:0]  cur_i, spawn_slot;
    logic [CNT_W-1:0]   cur_free;
    logic [SLOT_W-1:0]  cur_free_i;
    logic [19:0]        rem, t_sel;
    logic [20:0]        age_sum;
    logic [19:0]        age_next;
    logic [7:0]         ch_col;
    logic [27:0]        age255;
    logic signed [24:0] mul_a;
    logic signed [20:0] mul_b;
    logic [NUM_W-1:0]   div_num;
    t_div_sts           div_sts;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign emit_go     = (r_state == S_EMIT) && out_free;
    assign spawn_go    = (r_state == S_SPAWN) && out_free;
    assign load_out    = emit_go || spawn_go;

    assign cur        = r_idx - 1'b1;
    assign cur_i      = cur[SLOT_W-1:0];
    assign dead       = (r_age > r_span);
    assign skip       = (r_age >= r_span);
    assign rem        = r_span - r_age;
    assign t_sel      = (r_age < r_tail) ? r_age : r_tail;
    assign ch_col     = r_col[8*r_ch +: 8];
    assign age255     = {r_age, 8'd0} - 28'(r_age);
    assign age_sum    = {1'b0, r_age} + 21'(r_in.time_step);
    assign age_next   = age_sum[20] ? 20'hFFFFF : age_sum[19:0];
    assign spawn_full = (r_free_cnt == '0) || (r_live_cnt >= CNT_W'(PARTICLES));
    assign cur_free   = r_free_cnt - 1'b1;
    assign cur_free_i = cur_free[SLOT_W-1:0];
    assign spawn_slot = r_free_stk[cur_free_i];

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MVX: begin
                mul_a = 25'(r_vx);
                mul_b = 21'(r_in.time_step);
            end
            S_MVY: begin
                mul_a = 25'(r_vy);
                mul_b = 21'(r_in.time_step);
            end
            S_MG: begin
                mul_a = 25'(r_gravity);
                mul_b = 21'(r_in.time_step);
            end
            S_TX: begin
                mul_a = 25'(r_vx);
                mul_b = 21'(t_sel);
            end
            S_TY: begin
                mul_a = 25'(r_vy);
                mul_b = 21'(t_sel);
            end
            S_DMUL: begin
                mul_a = 25'(ch_col);
                mul_b = 21'(rem);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Dividend for the rounded life-fraction scaling of one channel.
    always_comb begin
        div_num = NUM_W'({r_prod[28:0], 1'b0}) + NUM_W'(r_span);
        if (r_ch == 2'd3) begin
            div_num = div_num + NUM_W'({age255, 1'b0});
        end
    end

    ppu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DSET),
        .i_num   (div_num),
        .i_den   ({r_span, 1'b0}),
        .o_sts   (div_sts)
    );

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.op == OP_SPAWN) begin
                        n_state = S_SPAWN;
                    end else if (r_live_cnt != '0) begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_SPAWN: if (out_free) n_state = S_IDLE;
            S_FETCH: n_state = S_MVX;
            S_MVX:   n_state = S_MVY;
            S_MVY:   n_state = S_MG;
            S_MG:    n_state = S_AGE;
            S_AGE:   n_state = S_TX;
            S_TX:    n_state = S_TY;
            S_TY:    n_state = S_TEND;
            S_TEND:  n_state = skip ? S_EMIT : S_DMUL;
            S_DMUL:  n_state = S_DSET;
            S_DSET:  n_state = S_DWAIT;
            S_DWAIT: begin
                if (div_sts.done) begin
                    n_state = (r_ch == 2'd3) ? S_EMIT : S_DMUL;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = (r_idx == CNT_W'(1)) ? S_IDLE : S_FETCH;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Result word assembly.
    always_comb begin
        n_out = '0;
        if (r_state == S_SPAWN) begin
            n_out.kind = spawn_full ? KIND_DROPPED : KIND_SPAWNED;
            n_out.slot = spawn_full ? 5'd0 : 5'(spawn_slot);
            n_out.last = 1'b1;
        end else begin
            n_out.kind       = KIND_REPORT;
            n_out.slot       = 5'(r_slot);
            n_out.head_x     = r_px;
            n_out.head_y     = r_py;
            n_out.tail_x     = dead ? 24'sd0 : r_tx;
            n_out.tail_y     = dead ? 24'sd0 : r_ty;
            n_out.fade_red   = r_fade[0];
            n_out.fade_green = r_fade[1];
            n_out.fade_blue  = r_fade[2];
            n_out.head_alpha = r_ha;
            n_out.expired    = dead;
            n_out.last       = (r_idx == CNT_W'(1));
        end
    end

    // Control state: registers, pool bookkeeping, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity   <= GRAVITY_RST;
            r_tail      <= TAIL_RST;
            r_free_cnt  <= CNT_W'(PARTICLES);
            r_live_cnt  <= '0;
            r_idx       <= '0;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < PARTICLES; i++) begin
                r_free_stk[i] <= SLOT_W'(i);
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_GRAVITY: r_gravity <= i_cfg_data[15:0];
                    CFG_TAIL:    r_tail    <= i_cfg_data;
                    default:     r_tail    <= r_tail;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end
            if (in_acc) begin
                r_idx <= r_live_cnt;
            end
            if (r_state == S_TEND) begin
                r_ch <= '0;
            end else if ((r_state == S_DWAIT) && div_sts.done) begin
                r_ch <= r_ch + 1'b1;
            end
            if (spawn_go && !spawn_full) begin
                r_free_cnt <= r_free_cnt - 1'b1;
                r_live_cnt <= r_live_cnt + 1'b1;
            end
            if (emit_go) begin
                r_idx <= r_idx - 1'b1;
                if (dead) begin
                    r_live_cnt <= r_live_cnt - 1'b1;
                    if (r_free_cnt < CNT_W'(PARTICLES)) begin
                        r_free_stk[r_free_cnt[SLOT_W-1:0]] <= r_slot;
                        r_free_cnt <= r_free_cnt + 1'b1;
                    end
                end
            end
        end
    end

    // Live order list: append on spawn, close the gap on expiry.
    always_ff @(posedge i_clk) begin
        if (spawn_go && !spawn_full) begin
            r_live[r_live_cnt[SLOT_W-1:0]] <= spawn_slot;
        end
        if (emit_go && dead) begin
            for (int j = 0; j < PARTICLES - 1; j++) begin
                if ((CNT_W'(j) >= cur) && (CNT_W'(j + 1) < r_live_cnt)) begin
                    r_live[j] <= r_live[j + 1];
                end
            end
        end
    end

    // Particle stores: filled on spawn, written back after each update.
    always_ff @(posedge i_clk) begin
        if (spawn_go && !spawn_full) begin
            r_pos_x_st[spawn_slot] <= r_in.pos_x;
            r_pos_y_st[spawn_slot] <= r_in.pos_y;
            r_vel_x_st[spawn_slot] <= r_in.vel_x;
            r_vel_y_st[spawn_slot] <= r_in.vel_y;
            r_col_st[spawn_slot]   <= {r_in.alpha, r_in.blue, r_in.green, r_in.red};
            r_span_st[spawn_slot]  <= r_in.life_span;
            r_age_st[spawn_slot]   <= '0;
        end else if (emit_go) begin
            r_pos_x_st[r_slot] <= r_px;
            r_pos_y_st[r_slot] <= r_py;
            r_vel_y_st[r_slot] <= r_vy;
            r_age_st[r_slot]   <= r_age;
        end
    end

    // Update datapath around the shared multiplier.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (load_out) begin
            r_out <= n_out;
        end
        case (r_state)
            S_FETCH: begin
                r_slot <= r_live[cur_i];
                r_px   <= r_pos_x_st[r_live[cur_i]];
                r_py   <= r_pos_y_st[r_live[cur_i]];
                r_vx   <= r_vel_x_st[r_live[cur_i]];
                r_vy   <= r_vel_y_st[r_live[cur_i]];
                r_age  <= r_age_st[r_live[cur_i]];
                r_span <= r_span_st[r_live[cur_i]];
                r_col  <= r_col_st[r_live[cur_i]];
            end
            S_MVY: r_px <= sat24(31'(r_px) + 31'(rnd16(r_prod)));
            S_MG:  r_py <= sat24(31'(r_py) + 31'(rnd16(r_prod)));
            S_AGE: begin
                r_vy  <= sat24(31'(r_vy) + 31'(rnd16(r_prod)));
                r_age <= age_next;
            end
            S_TY: r_tx <= sat24(31'(r_px) - 31'(rnd16(r_prod)));
            S_TEND: begin
                r_ty <= sat24(31'(r_py) - 31'(rnd16(r_prod)));
                if (skip) begin
                    r_fade[0] <= '0;
                    r_fade[1] <= '0;
                    r_fade[2] <= '0;
                    r_ha      <= 8'd255;
                end
            end
            S_DWAIT: begin
                if (div_sts.done) begin
                    if (r_ch == 2'd3) begin
                        r_ha <= div_sts.quot;
                    end else begin
                        r_fade[r_ch] <= div_sts.quot;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Between input words every slot is either free or live.
    `PPU_ASSERT_IMP(a_pool_conserved, r_state == S_IDLE, (CNT_W+1)'(r_free_cnt) + (CNT_W+1)'(r_live_cnt) == (CNT_W+1)'(PARTICLES), "slot count lost")
    // The divider finishes only while the sequencer waits for it.
    `PPU_ASSERT_IMP(a_div_done_in_wait, div_sts.done, r_state == S_DWAIT, "stray divider result")
    // After the final word of an input the block returns to idle.
    `PPU_ASSERT_NXT(a_last_to_idle, load_out && n_out.last, r_state == S_IDLE, "busy after last word")

endmodule
